### design/pdp_pkg.sv
// Shared types, register indexes, status codes and fixed-point helpers
// for the pinhole projection pipeline. No dependencies.
package pdp_pkg;

   typedef enum logic [2:0] {
      REG_FOCAL_X    = 3'd0,
      REG_FOCAL_Y    = 3'd1,
      REG_PRINCIPAL  = 3'd2,
      REG_K1         = 3'd3,
      REG_K2         = 3'd4,
      REG_K3         = 3'd5,
      REG_TANGENTIAL = 3'd6,
      REG_DIST_EN    = 3'd7
   } reg_index_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DEPTH = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic signed [63:0] NORM_ONE = 64'sd16777216;
   localparam logic signed [63:0] HALF_LSB = 64'sd8388608;
   localparam int NORM_FRAC = 24;

   typedef struct packed {
      logic valid;
      logic bad;
      logic sat;
   } side_type;

   typedef struct packed {
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
      logic               en;
   } dist_cfg_type;

   typedef struct packed {
      logic        [31:0] fx;
      logic        [31:0] fy;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
   } proj_cfg_type;

   function automatic logic signed [63:0] sx(input logic signed [31:0] a);
      sx = {{32{a[31]}}, a};
   endfunction

   // {clamped, value}
   function automatic logic [32:0] sat64(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat64 = {1'b1, 32'h7fff_ffff};
      end else if (v < -64'sd2147483648) begin
         sat64 = {1'b1, 32'h8000_0000};
      end else begin
         sat64 = {1'b0, v[31:0]};
      end
   endfunction

   // round to nearest (ties up) dropping 24 bits, then clamp
   function automatic logic [32:0] rnd64(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + HALF_LSB) >>> NORM_FRAC;
      rnd64 = sat64(t);
   endfunction

   // eight restoring division steps: {remainder, quotient bits}
   function automatic logic [39:0] div_step8(input logic [31:0] rem,
                                             input logic [30:0] den,
                                             input logic [7:0]  bits);
      logic [32:0] t;
      logic [31:0] r;
      logic [7:0]  q;
      r = rem;
      q = 8'd0;
      for (int i = 7; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {2'b00, den}) begin
            t = t - {2'b00, den};
            q[i] = 1'b1;
         end
         r = t[31:0];
      end
      div_step8 = {r, q};
   endfunction

endpackage

### design/pdp_div.sv
// Pipelined divider for both coordinates: x * 2^24 / z, truncated and clamped.
// Depends on pdp_pkg.
module pdp_div
   import pdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  side_type           in_side,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   output side_type           out_side,
   output logic signed [31:0] out_xn,
   output logic signed [31:0] out_yn
);

   side_type    side_ff [5];
   logic [30:0] den_ff  [5];
   logic [31:0] rem_ff  [5][2];
   logic [31:0] feed_ff [5][2];
   logic [31:0] q_ff    [5][2];
   logic        neg_ff  [5][2];
   logic        ovf_ff  [5][2];

   side_type           oside_ff;
   logic signed [31:0] xn_ff;
   logic signed [31:0] yn_ff;

   logic [31:0] mag_in [2];
   logic [32:0] res    [2];
   logic signed [31:0] coord_in [2];

   always_comb begin
      coord_in[0] = in_x;
      coord_in[1] = in_y;
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = coord_in[l][31] ? 32'(-coord_in[l]) : coord_in[l];
      end
      for (int l = 0; l < 2; l++) begin
         if (!neg_ff[4][l]) begin
            if (ovf_ff[4][l] || q_ff[4][l][31]) res[l] = {1'b1, 32'h7fff_ffff};
            else                                res[l] = {1'b0, q_ff[4][l]};
         end else begin
            if (ovf_ff[4][l] || q_ff[4][l] > 32'h8000_0000) res[l] = {1'b1, 32'h8000_0000};
            else                                             res[l] = {1'b0, -q_ff[4][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [39:0] st;
      if (adv) begin
         den_ff[0] <= in_z[30:0];
         for (int l = 0; l < 2; l++) begin
            neg_ff[0][l]  <= coord_in[l][31];
            ovf_ff[0][l]  <= {8'd0, mag_in[l]} >= {1'b0, in_z[30:0], 8'd0};
            rem_ff[0][l]  <= {8'd0, mag_in[l][31:8]};
            feed_ff[0][l] <= {mag_in[l][7:0], 24'd0};
            q_ff[0][l]    <= 32'd0;
         end
         for (int k = 0; k < 4; k++) begin
            den_ff[k+1] <= den_ff[k];
            for (int l = 0; l < 2; l++) begin
               st = div_step8(rem_ff[k][l], den_ff[k], feed_ff[k][l][31:24]);
               rem_ff[k+1][l]  <= st[39:8];
               q_ff[k+1][l]    <= {q_ff[k][l][23:0], st[7:0]};
               feed_ff[k+1][l] <= {feed_ff[k][l][23:0], 8'd0};
               neg_ff[k+1][l]  <= neg_ff[k][l];
               ovf_ff[k+1][l]  <= ovf_ff[k][l];
            end
         end
         xn_ff <= res[0][31:0];
         yn_ff <= res[1][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) side_ff[k] <= '0;
         oside_ff <= '0;
      end else if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 0; k < 4; k++) side_ff[k+1] <= side_ff[k];
         oside_ff <= '{valid: side_ff[4].valid, bad: side_ff[4].bad,
                       sat: side_ff[4].sat | res[0][32] | res[1][32]};
      end
   end

   assign out_side = oside_ff;
   assign out_xn   = xn_ff;
   assign out_yn   = yn_ff;

endmodule

### design/pdp_distort.sv
// Brown-Conrady radial and tangential distortion, ten register stages.
// Depends on pdp_pkg.
module pdp_distort
   import pdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  dist_cfg_type       cfg,
   input  side_type           in_side,
   input  logic signed [31:0] in_xn,
   input  logic signed [31:0] in_yn,
   output side_type           out_side,
   output logic signed [31:0] out_xs,
   output logic signed [31:0] out_ys
);

   side_type side_ff [10];
   logic signed [31:0] xn_ff [9];
   logic signed [31:0] yn_ff [9];

   logic signed [63:0] pxx_ff, pyy_ff, pxy_ff;
   logic signed [31:0] x2_ff, y2_ff, xy_ff, r2_ff [2:4];
   logic signed [63:0] prr_ff, pk1_ff, pa1_ff, pa2_ff;
   logic signed [31:0] tax_ff [3:4], tay_ff [3:4];
   logic signed [31:0] r4_ff, k1r2_ff [4:7], a1_ff [4:9], a2_ff [4:9];
   logic signed [63:0] pr6_ff, pk2_ff, ptx_ff, pty_ff;
   logic signed [31:0] r6_ff, k2r4_ff [6:7], tx_ff [6:9], ty_ff [6:9];
   logic signed [63:0] pk3_ff;
   logic signed [31:0] rad_ff;
   logic signed [63:0] pxr_ff, pyr_ff;
   logic signed [31:0] xs_ff, ys_ff;

   logic [32:0] x2_c, y2_c, xy_c, r2_c, tax_c, tay_c;
   logic [32:0] r4_c, k1r2_c, a1_c, a2_c;
   logic [32:0] r6_c, k2r4_c, tx_c, ty_c;
   logic [32:0] k3r6_c, rad_c, xr_c, yr_c, xd_c, yd_c;
   logic        f2, f3, f4, f6, f8, f10;

   always_comb begin
      x2_c = rnd64(pxx_ff);
      y2_c = rnd64(pyy_ff);
      xy_c = rnd64(pxy_ff);
      r2_c = sat64(sx(x2_c[31:0]) + sx(y2_c[31:0]));
      f2   = x2_c[32] | y2_c[32] | xy_c[32] | r2_c[32];

      tax_c = sat64(sx(r2_ff[2]) + 2 * sx(x2_ff));
      tay_c = sat64(sx(r2_ff[2]) + 2 * sx(y2_ff));
      f3    = tax_c[32] | tay_c[32];

      r4_c   = rnd64(prr_ff);
      k1r2_c = rnd64(pk1_ff);
      a1_c   = rnd64(pa1_ff);
      a2_c   = rnd64(pa2_ff);
      f4     = r4_c[32] | k1r2_c[32] | a1_c[32] | a2_c[32];

      r6_c   = rnd64(pr6_ff);
      k2r4_c = rnd64(pk2_ff);
      tx_c   = rnd64(ptx_ff);
      ty_c   = rnd64(pty_ff);
      f6     = r6_c[32] | k2r4_c[32] | tx_c[32] | ty_c[32];

      k3r6_c = rnd64(pk3_ff);
      rad_c  = sat64(NORM_ONE + sx(k1r2_ff[7]) + sx(k2r4_ff[7]) + sx(k3r6_c[31:0]));
      f8     = k3r6_c[32] | rad_c[32];

      xr_c = rnd64(pxr_ff);
      yr_c = rnd64(pyr_ff);
      xd_c = sat64(sx(xr_c[31:0]) + 2 * sx(a1_ff[9]) + sx(tx_ff[9]));
      yd_c = sat64(sx(yr_c[31:0]) + sx(ty_ff[9]) + 2 * sx(a2_ff[9]));
      f10  = xr_c[32] | yr_c[32] | xd_c[32] | yd_c[32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xn_ff[0] <= in_xn;
         yn_ff[0] <= in_yn;
         for (int k = 0; k < 8; k++) begin
            xn_ff[k+1] <= xn_ff[k];
            yn_ff[k+1] <= yn_ff[k];
         end
         pxx_ff <= in_xn * in_xn;
         pyy_ff <= in_yn * in_yn;
         pxy_ff <= in_xn * in_yn;

         x2_ff    <= x2_c[31:0];
         y2_ff    <= y2_c[31:0];
         xy_ff    <= xy_c[31:0];
         r2_ff[2] <= r2_c[31:0];

         prr_ff    <= r2_ff[2] * r2_ff[2];
         pk1_ff    <= cfg.k1 * r2_ff[2];
         pa1_ff    <= cfg.p1 * xy_ff;
         pa2_ff    <= cfg.p2 * xy_ff;
         r2_ff[3]  <= r2_ff[2];
         tax_ff[3] <= tax_c[31:0];
         tay_ff[3] <= tay_c[31:0];

         r4_ff      <= r4_c[31:0];
         k1r2_ff[4] <= k1r2_c[31:0];
         a1_ff[4]   <= a1_c[31:0];
         a2_ff[4]   <= a2_c[31:0];
         r2_ff[4]   <= r2_ff[3];
         tax_ff[4]  <= tax_ff[3];
         tay_ff[4]  <= tay_ff[3];

         pr6_ff <= r4_ff * r2_ff[4];
         pk2_ff <= cfg.k2 * r4_ff;
         ptx_ff <= cfg.p2 * tax_ff[4];
         pty_ff <= cfg.p1 * tay_ff[4];
         for (int k = 4; k < 7; k++) k1r2_ff[k+1] <= k1r2_ff[k];
         for (int k = 4; k < 9; k++) begin
            a1_ff[k+1] <= a1_ff[k];
            a2_ff[k+1] <= a2_ff[k];
         end

         r6_ff      <= r6_c[31:0];
         k2r4_ff[6] <= k2r4_c[31:0];
         tx_ff[6]   <= tx_c[31:0];
         ty_ff[6]   <= ty_c[31:0];
         for (int k = 6; k < 7; k++) k2r4_ff[k+1] <= k2r4_ff[k];
         for (int k = 6; k < 9; k++) begin
            tx_ff[k+1] <= tx_ff[k];
            ty_ff[k+1] <= ty_ff[k];
         end

         pk3_ff <= cfg.k3 * r6_ff;
         rad_ff <= rad_c[31:0];
         pxr_ff <= xn_ff[7] * rad_ff;
         pyr_ff <= yn_ff[7] * rad_ff;

         xs_ff <= cfg.en ? xd_c[31:0] : xn_ff[8];
         ys_ff <= cfg.en ? yd_c[31:0] : yn_ff[8];
      end
   end

   logic     flag [9];

   always_comb begin
      for (int k = 0; k < 9; k++) flag[k] = 1'b0;
      flag[0] = f2;
      flag[1] = f3;
      flag[2] = f4;
      flag[4] = f6;
      flag[6] = f8;
      flag[8] = f10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 10; k++) side_ff[k] <= '0;
      end else if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 0; k < 9; k++) begin
            side_ff[k+1] <= '{valid: side_ff[k].valid, bad: side_ff[k].bad,
                              sat: side_ff[k].sat | (cfg.en & flag[k])};
         end
      end
   end

   assign out_side = side_ff[9];
   assign out_xs   = xs_ff;
   assign out_ys   = ys_ff;

endmodule

### design/pdp_project.sv
// Focal scaling and principal point offset, two stages ending in the
// output register. Depends on pdp_pkg.
module pdp_project
   import pdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  proj_cfg_type       cfg,
   input  side_type           in_side,
   input  logic signed [31:0] in_xs,
   input  logic signed [31:0] in_ys,
   output logic               out_valid,
   output logic signed [31:0] out_u,
   output logic signed [31:0] out_v,
   output logic [1:0]         out_status
);

   side_type           side_ff;
   logic signed [63:0] pu_ff, pv_ff;
   logic               valid_ff;
   logic signed [31:0] u_ff, v_ff;
   logic [1:0]         status_ff;
   logic [32:0]        u_c, v_c;

   always_comb begin
      u_c = sat64(((pu_ff + HALF_LSB) >>> NORM_FRAC) + sx(cfg.cx));
      v_c = sat64(((pv_ff + HALF_LSB) >>> NORM_FRAC) + sx(cfg.cy));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pu_ff <= $signed({1'b0, cfg.fx}) * in_xs;
         pv_ff <= $signed({1'b0, cfg.fy}) * in_ys;
         if (side_ff.bad) begin
            u_ff      <= '0;
            v_ff      <= '0;
            status_ff <= ST_DEPTH;
         end else begin
            u_ff      <= u_c[31:0];
            v_ff      <= v_c[31:0];
            status_ff <= (side_ff.sat | u_c[32] | v_c[32]) ? ST_SAT : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (adv) begin
         side_ff  <= in_side;
         valid_ff <= side_ff.valid;
      end
   end

   assign out_valid  = valid_ff;
   assign out_u      = u_ff;
   assign out_v      = v_ff;
   assign out_status = status_ff;

endmodule

### design/pinhole_distort_project.sv
// Pinhole projection with optional lens distortion: one point in, one pixel out.
// Depends on pdp_pkg, pdp_div, pdp_distort and pdp_project.
//
// Accepts one item per cycle and passes each through six stages of the divider
// (four of them eight quotient bits each), ten distortion stages built around
// the chain of multiplications, and two projection stages ending in the output
// register. The whole pipeline moves as one; it holds while a result waits
// untaken and ready drops then. The user must write configuration through
// csr_we/csr_index/csr_wdata only while idle; the block does not enforce it.
module pinhole_distort_project
   import pdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // point_x, point_y, point_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pixel_u, pixel_v
   output logic [1:0]  rsp_tuser    // status
);

   logic [31:0] focal_x_ff, focal_y_ff;
   logic [63:0] principal_ff, tangential_ff;
   logic [31:0] k1_ff, k2_ff, k3_ff;
   logic        dist_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff    <= 32'd65536;
         focal_y_ff    <= 32'd65536;
         principal_ff  <= '0;
         k1_ff         <= '0;
         k2_ff         <= '0;
         k3_ff         <= '0;
         tangential_ff <= '0;
         dist_en_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FOCAL_X:    focal_x_ff    <= csr_wdata[31:0];
            REG_FOCAL_Y:    focal_y_ff    <= csr_wdata[31:0];
            REG_PRINCIPAL:  principal_ff  <= csr_wdata;
            REG_K1:         k1_ff         <= csr_wdata[31:0];
            REG_K2:         k2_ff         <= csr_wdata[31:0];
            REG_K3:         k3_ff         <= csr_wdata[31:0];
            REG_TANGENTIAL: tangential_ff <= csr_wdata;
            REG_DIST_EN:    dist_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   dist_cfg_type dcfg;
   proj_cfg_type pcfg;

   assign dcfg = '{k1: k1_ff, k2: k2_ff, k3: k3_ff, p1: tangential_ff[63:32],
                   p2: tangential_ff[31:0], en: dist_en_ff};
   assign pcfg = '{fx: focal_x_ff, fy: focal_y_ff, cx: principal_ff[63:32],
                   cy: principal_ff[31:0]};

   logic     adv;
   side_type in_side, div_side, dis_side;
   logic signed [31:0] xn, yn, xs, ys, pu, pv;
   logic signed [31:0] pz;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign pz         = req_tdata[95:64];
   assign in_side    = '{valid: req_tvalid, bad: (pz[31] || pz == 32'sd0), sat: 1'b0};

   pdp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_side  (in_side),
      .in_x     (req_tdata[31:0]),
      .in_y     (req_tdata[63:32]),
      .in_z     (pz),
      .out_side (div_side),
      .out_xn   (xn),
      .out_yn   (yn)
   );

   pdp_distort u_distort (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (dcfg),
      .in_side  (div_side),
      .in_xn    (xn),
      .in_yn    (yn),
      .out_side (dis_side),
      .out_xs   (xs),
      .out_ys   (ys)
   );

   pdp_project u_project (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (pcfg),
      .in_side    (dis_side),
      .in_xs      (xs),
      .in_ys      (ys),
      .out_valid  (rsp_tvalid),
      .out_u      (pu),
      .out_v      (pv),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = {pv, pu};

   a_depth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DEPTH |-> rsp_tdata == 64'd0)
      else $error("depth fault with nonzero pixels");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined status code");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline stalled");

endmodule

### verif/tb.sv
// Self-checking testbench for pinhole_distort_project: directed table, then random phases.
// Each phase loads a new register setting. Points go in; every returned pixel is compared
// with its table pixel if typed, or a fixed-point projection predictor. Depends on pdp_pkg.
module tb;
   import pdp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 18;
   localparam int CYCLE_LIMIT = 600000;
   localparam int INT_MAX = 32'h7fff_ffff;
   localparam int INT_MIN = 32'h8000_0000;
   localparam int ONE_Q16 = 65536;

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic [1:0]         st;
   } pixel_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               typed;
      pixel_type          px;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   pinhole_distort_project u_top (.*);

   always #4 clock = ~clock;

   // predictor copy of the registers
   logic [31:0] fx_q = 32'd65536;
   logic [31:0] fy_q = 32'd65536;
   logic [63:0] pp_q = '0;
   logic [31:0] k1_q = '0, k2_q = '0, k3_q = '0;
   logic [63:0] tp_q = '0;
   logic        den_q = 1'b0;

   pixel_type pixel_q[$];
   int     err_count = 0;
   int     cycle_count = 0;
   bit     clamp_hit;
   bit     no_gaps = 0;
   bit     hold_tog = 0, hold_ack = 0;
   int     hold_cnt = 0, rdy_idle = 0;
   dir_row_type dir_tab[11];

   function automatic longint clamp32(longint v);
      if (v > longint'(INT_MAX)) begin
         clamp_hit = 1;
         return longint'(INT_MAX);
      end
      if (v < -64'sd2147483648) begin
         clamp_hit = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint mul_q24(longint a, longint b);
      return clamp32((a * b + 64'sd8388608) >>> 24);
   endfunction

   function automatic longint sx32(logic [31:0] w);
      return longint'(signed'(w));
   endfunction

   function automatic pixel_type project_point(logic signed [31:0] px, py, pz);
      pixel_type r;
      longint x, y, z, xn, yn, u, v;
      longint x2, y2, xy, r2, r4, r6, rad, tx, ty, xd, yd, p1, p2;
      clamp_hit = 0;
      x = px; y = py; z = pz;
      if (z <= 0) begin
         r = '{u: 0, v: 0, st: ST_DEPTH};
         return r;
      end
      xn = clamp32((x * 64'sd16777216) / z);
      yn = clamp32((y * 64'sd16777216) / z);
      if (den_q) begin
         p1 = sx32(tp_q[63:32]);
         p2 = sx32(tp_q[31:0]);
         x2 = mul_q24(xn, xn);
         y2 = mul_q24(yn, yn);
         xy = mul_q24(xn, yn);
         r2 = clamp32(x2 + y2);
         r4 = mul_q24(r2, r2);
         r6 = mul_q24(r4, r2);
         rad = clamp32(64'sd16777216 + mul_q24(sx32(k1_q), r2) + mul_q24(sx32(k2_q), r4)
                       + mul_q24(sx32(k3_q), r6));
         tx = mul_q24(p2, clamp32(r2 + 2 * x2));
         ty = mul_q24(p1, clamp32(r2 + 2 * y2));
         xd = clamp32(mul_q24(xn, rad) + 2 * mul_q24(p1, xy) + tx);
         yd = clamp32(mul_q24(yn, rad) + ty + 2 * mul_q24(p2, xy));
         xn = xd;
         yn = yd;
      end
      u = ((longint'({32'b0, fx_q}) * xn + 64'sd8388608) >>> 24) + sx32(pp_q[63:32]);
      v = ((longint'({32'b0, fy_q}) * yn + 64'sd8388608) >>> 24) + sx32(pp_q[31:0]);
      u = clamp32(u);
      v = clamp32(v);
      r.u = u[31:0];
      r.v = v[31:0];
      r.st = clamp_hit ? ST_SAT : ST_OK;
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("tb: mismatch %s got %h want %h (cycle %0d)", what, got, want, cycle_count);
      err_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      pixel_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            report("unexpected item", rsp_tdata[31:0], 0);
         end else begin
            w = pixel_q.pop_front();
            if (rsp_tdata[31:0] !== w.u) report("pixel_u", rsp_tdata[31:0], w.u);
            if (rsp_tdata[63:32] !== w.v) report("pixel_v", rsp_tdata[63:32], w.v);
            if (rsp_tuser !== w.st) report("status", rsp_tuser, w.st);
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (hold_tog != hold_ack) begin
         hold_ack <= hold_tog;
         hold_cnt <= 300;
         rsp_tready <= 1'b0;
      end else if (rdy_idle > 0) begin
         rdy_idle <= rdy_idle - 1;
         rsp_tready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (no_gaps || r < 80) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rdy_idle <= (r < 97) ? $urandom_range(0, 2) : $urandom_range(15, 50);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_point(logic signed [31:0] x, y, z, bit typed, pixel_type want);
      int gap;
      req_tdata <= {z, y, x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixel_q.push_back(typed ? want : project_point(x, y, z));
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
   endtask

   task automatic load_regs(logic [63:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      fx_q = vals[REG_FOCAL_X][31:0];
      fy_q = vals[REG_FOCAL_Y][31:0];
      pp_q = vals[REG_PRINCIPAL];
      k1_q = vals[REG_K1][31:0];
      k2_q = vals[REG_K2][31:0];
      k3_q = vals[REG_K3][31:0];
      tp_q = vals[REG_TANGENTIAL];
      den_q = vals[REG_DIST_EN][0];
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [31:0] small_coef(int span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   task automatic pick_setting(int kind);
      logic [63:0] vals[8];
      case (kind)
         0, 1: begin
            vals[REG_FOCAL_X] = {$urandom(), 32'($urandom_range(100, 3000)) << 16};
            vals[REG_FOCAL_Y] = {$urandom(), 32'($urandom_range(100, 3000)) << 16};
            vals[REG_PRINCIPAL] = {32'($urandom_range(0, 1920)) << 16,
                                   32'($urandom_range(0, 1080)) << 16};
            vals[REG_K1] = {$urandom(), small_coef(8388608)};
            vals[REG_K2] = {$urandom(), small_coef(4194304)};
            vals[REG_K3] = {$urandom(), small_coef(1048576)};
            vals[REG_TANGENTIAL] = {small_coef(200000), small_coef(200000)};
            vals[REG_DIST_EN] = {$urandom(), $urandom()} & ~64'd1 | 64'(kind == 0);
         end
         2: begin
            vals[REG_FOCAL_X] = '1;
            vals[REG_FOCAL_Y] = '1;
            vals[REG_PRINCIPAL] = {32'h7fff_ffff, 32'h8000_0000};
            vals[REG_K1] = 64'h7fff_ffff;
            vals[REG_K2] = 64'h7fff_ffff;
            vals[REG_K3] = 64'h7fff_ffff;
            vals[REG_TANGENTIAL] = {32'h7fff_ffff, 32'h7fff_ffff};
            vals[REG_DIST_EN] = 64'd1;
         end
         3: begin
            vals[REG_FOCAL_X] = '0;
            vals[REG_FOCAL_Y] = '0;
            vals[REG_PRINCIPAL] = {32'h8000_0000, 32'h7fff_ffff};
            vals[REG_K1] = 64'h8000_0000;
            vals[REG_K2] = 64'h8000_0000;
            vals[REG_K3] = 64'h8000_0000;
            vals[REG_TANGENTIAL] = {32'h8000_0000, 32'h8000_0000};
            vals[REG_DIST_EN] = 64'd1;
         end
         default: begin
            for (int i = 0; i < 8; i++) vals[i] = rnd64();
         end
      endcase
      load_regs(vals);
   endtask

   task automatic send_random_point();
      int r, z, x, y;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         z = $urandom_range(16384, 100 * ONE_Q16);
         x = $urandom_range(0, 2 * z) - z;
         y = $urandom_range(0, 2 * z) - z;
      end else if (r == 7) begin
         z = $urandom(); x = $urandom(); y = $urandom();
      end else if (r == 8) begin
         z = ($urandom_range(0, 3) == 0) ? 0 : -int'($urandom_range(0, INT_MAX)) - 1;
         x = $urandom(); y = $urandom();
      end else begin
         z = ONE_Q16;
         x = $urandom_range(0, 4 * ONE_Q16) - 2 * ONE_Q16;
         y = $urandom_range(0, 4 * ONE_Q16) - 2 * ONE_Q16;
      end
      send_point(x, y, z, 1'b0, '0);
   endtask

   initial begin
      int kinds[9] = '{0, 1, 0, 2, 0, 3, 4, 0, 4};
      dir_tab[0]  = '{0, 0, ONE_Q16, 1, '{0, 0, ST_OK}};
      dir_tab[1]  = '{123, 456, 0, 1, '{0, 0, ST_DEPTH}};
      dir_tab[2]  = '{INT_MAX, INT_MIN, -1, 1, '{0, 0, ST_DEPTH}};
      dir_tab[3]  = '{INT_MIN, INT_MAX, INT_MIN, 1, '{0, 0, ST_DEPTH}};
      dir_tab[4]  = '{3 * ONE_Q16, -2 * ONE_Q16, ONE_Q16, 1,
                      '{3 * ONE_Q16, -2 * ONE_Q16, ST_OK}};
      dir_tab[5]  = '{INT_MAX, INT_MIN, 1, 0, '0};
      dir_tab[6]  = '{INT_MAX, INT_MAX, INT_MAX, 0, '0};
      dir_tab[7]  = '{INT_MIN, INT_MIN, 1, 0, '0};
      dir_tab[8]  = '{1, -1, INT_MAX, 0, '0};
      dir_tab[9]  = '{0, 0, 1, 0, '0};
      dir_tab[10] = '{INT_MIN, INT_MAX, ONE_Q16, 0, '0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].px);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         pick_setting(kinds[ph]);
         no_gaps = (ph == 4);
         if (ph == 2) hold_tog = ~hold_tog;
         for (int n = 0; n < 100; n++) send_random_point();
         drain();
      end

      if (err_count == 0 && pixel_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
